### sv/vertex_normal_accumulator_unit_assert.svh
// Assertion macros for the vertex normal accumulator.
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VNA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vertex normal accumulator assertion failed");
`define VNA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vertex normal accumulator assertion failed");
`else
`define VNA_ASSERT(lbl, prop)
`define VNA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### sv/vna_pkg.sv
// Types and constants of the vertex normal accumulator.
`default_nettype none
package vna_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;
  localparam int IDX_W      = 10;
  localparam int MUL_W      = 31;
  localparam int CNT_W      = 5;
  localparam int SQRT_STEPS = 32;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POS_RD,
    ST_CROSS,
    ST_MAG,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIV_LD,
    ST_DIV,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_VLOAD,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

### sv/vertex_normal_accumulator_unit.sv
// Vertex normal accumulator: positions, face normal accumulation and normalized readout.
//
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    kind in tuser, indices and coordinates in tdata
// out_     out  out_tvalid/out_tready  is_zero in tuser, index and normal in tdata
//
// A position write is stored directly from the idle state; a clear sweeps the accumulators to zero.
// A triangle and a read bring the magnitudes into range by normalizing shift steps and then
// pass them through the bit-serial square root and divider. A degenerate triangle ends before
// the square root, and so does a zero read.
// After reset the accumulators are cleared by the same sweep before the first beat is taken.
// A read result waits in the output register while the next beat is accepted.
`default_nettype none
`include "vertex_normal_accumulator_unit_assert.svh"
module vertex_normal_accumulator_unit
  import vna_pkg::*;
#(
  parameter int VERTICES    = 1024,
  parameter int COORD_BITS  = 16,
  parameter int NORMAL_FRAC = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // index_a, index_b, index_c, coord_x, coord_y, coord_z from bit 0 up.
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // kind.
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // vertex_index, normal_x, normal_y, normal_z from bit 0 up.
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // is_zero.
  output logic [0:0]                 out_tuser
);

  localparam int AW = $clog2(VERTICES);
  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 1;
  localparam int VW = (2 * COORD_BITS + 3 > 33) ? 2 * COORD_BITS + 3 : 33;
  localparam int NW = NORMAL_FRAC + 2;
  localparam int QB = NORMAL_FRAC + 1;
  localparam int DW = NORMAL_FRAC + 34;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [1:0]                k_r, k_nxt;
  logic                      is_read_r, is_read_nxt;
  logic                      zero_r, zero_nxt;
  logic [AW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]             addr_r [3];
  logic [AW-1:0]             addr_nxt [3];
  logic [IDX_W-1:0]          vidx_r, vidx_nxt;
  logic signed [CW-1:0]      pa_r [3];
  logic signed [CW-1:0]      pa_nxt [3];
  logic signed [EW-1:0]      e1_r [3];
  logic signed [EW-1:0]      e1_nxt [3];
  logic signed [EW-1:0]      e2_r [3];
  logic signed [EW-1:0]      e2_nxt [3];
  logic signed [VW-1:0]      v_r [3];
  logic signed [VW-1:0]      v_nxt [3];
  logic [VW-1:0]             m_r [3];
  logic [VW-1:0]             m_nxt [3];
  logic signed [NW-1:0]      n_r [3];
  logic signed [NW-1:0]      n_nxt [3];
  logic signed [2*MUL_W-1:0] prod_r, prod_nxt;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic [63:0]               s_r, s_nxt, r_r, r_nxt, bit_r, bit_nxt, sq_t;
  logic [31:0]               len_r, len_nxt;
  logic [DW-1:0]             num_r, num_nxt, dsh_r, dsh_nxt;
  logic [QB-1:0]             q_r, q_nxt;
  logic                      div_ge;
  logic [VW-1:0]             or_m;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]     out_tdata_r, out_tdata_nxt;
  logic                      out_tuser_r, out_tuser_nxt;

  logic [IDX_W-1:0] in_ia, in_ib, in_ic;
  logic             ia_ok, ib_ok, ic_ok;
  logic [2:0]       cross_j;

  logic [3*CW-1:0] pos_mem [VERTICES];
  logic            pos_we;
  logic [AW-1:0]   pos_waddr, pos_raddr;
  logic [3*CW-1:0] pos_wdata, pos_rdata_r;

  logic [95:0]     acc_mem [VERTICES];
  logic            acc_we;
  logic [AW-1:0]   acc_waddr, acc_raddr;
  logic [95:0]     acc_wdata, acc_rdata_r;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [NW-1:0] b);
    logic [32:0] s;
    s = {a[31], a} + {{(33 - NW){b[NW-1]}}, b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  assign in_ia = in_tdata[9:0];
  assign in_ib = in_tdata[19:10];
  assign in_ic = in_tdata[29:20];
  assign ia_ok = (32'(in_ia) < VERTICES);
  assign ib_ok = (32'(in_ib) < VERTICES);
  assign ic_ok = (32'(in_ic) < VERTICES);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign or_m    = m_r[0] | m_r[1] | m_r[2];
  assign cross_j = cnt_r[2:0] - 3'd1;
  assign sq_t    = r_r + bit_r;
  assign div_ge  = (num_r >= dsh_r);
  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_CROSS) begin
      case (cnt_r[2:0])
        3'd0: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[2]); end
        3'd1: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[1]); end
        3'd2: begin mul_a = MUL_W'(e1_r[2]); mul_b = MUL_W'(e2_r[0]); end
        3'd3: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[2]); end
        3'd4: begin mul_a = MUL_W'(e1_r[0]); mul_b = MUL_W'(e2_r[1]); end
        3'd5: begin mul_a = MUL_W'(e1_r[1]); mul_b = MUL_W'(e2_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_r == ST_SQ && cnt_r < CNT_W'(3)) begin
      mul_a = $signed({1'b0, m_r[cnt_r[1:0]][29:0]});
      mul_b = $signed({1'b0, m_r[cnt_r[1:0]][29:0]});
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(VERTICES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          case (kind_t'(in_tuser))
            KIND_WRITE: state_nxt = ST_IDLE;
            KIND_TRI:   state_nxt = (ia_ok && ib_ok && ic_ok) ? ST_POS_RD : ST_IDLE;
            KIND_READ:  state_nxt = ia_ok ? ST_ACC_RD : ST_OUT;
            KIND_CLEAR: state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POS_RD: if (cnt_r == CNT_W'(3)) state_nxt = ST_CROSS;
      ST_CROSS:  if (cnt_r == CNT_W'(6)) state_nxt = ST_MAG;
      ST_MAG:    state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (or_m == '0) begin
          state_nxt = is_read_r ? ST_OUT : ST_IDLE;
        end else if ((|or_m[VW-1:30]) == 1'b0 && (|or_m[VW-1:29]) == 1'b1) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:     if (cnt_r == CNT_W'(3)) state_nxt = ST_SQRT;
      ST_SQRT:   if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = ST_DIV_LD;
      ST_DIV_LD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(QB - 1)) begin
          if (k_r == 2'd2) state_nxt = is_read_r ? ST_OUT : ST_ACC_RD;
          else state_nxt = ST_DIV_LD;
        end
      end
      ST_ACC_RD: state_nxt = is_read_r ? ST_VLOAD : ST_ACC_WR;
      ST_ACC_WR: state_nxt = (k_r == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_VLOAD:  state_nxt = ST_MAG;
      ST_OUT:    if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    is_read_nxt    = is_read_r;
    zero_nxt       = zero_r;
    clr_cnt_nxt    = clr_cnt_r;
    addr_nxt       = addr_r;
    vidx_nxt       = vidx_r;
    pa_nxt         = pa_r;
    e1_nxt         = e1_r;
    e2_nxt         = e2_r;
    v_nxt          = v_r;
    m_nxt          = m_r;
    n_nxt          = n_r;
    s_nxt          = s_r;
    r_nxt          = r_r;
    bit_nxt        = bit_r;
    len_nxt        = len_r;
    num_nxt        = num_r;
    dsh_nxt        = dsh_r;
    q_nxt          = q_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    pos_we         = 1'b0;
    pos_waddr      = AW'(in_ia);
    pos_wdata      = {CW'($signed(in_tdata[77:62])), CW'($signed(in_tdata[61:46])),
                      CW'($signed(in_tdata[45:30]))};
    pos_raddr      = addr_r[0];
    acc_we         = 1'b0;
    acc_waddr      = clr_cnt_r;
    acc_wdata      = '0;
    acc_raddr      = addr_r[k_r];
    case (state_r)
      ST_CLEAR: begin
        acc_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        clr_cnt_nxt = '0;
        cnt_nxt     = '0;
        k_nxt       = '0;
        addr_nxt[0] = AW'(in_ia);
        addr_nxt[1] = AW'(in_ib);
        addr_nxt[2] = AW'(in_ic);
        vidx_nxt    = in_ia;
        zero_nxt    = 1'b0;
        is_read_nxt = (kind_t'(in_tuser) == KIND_READ);
        if (in_tvalid && kind_t'(in_tuser) == KIND_WRITE && ia_ok) pos_we = 1'b1;
        if (in_tvalid && kind_t'(in_tuser) == KIND_READ && !ia_ok) begin
          zero_nxt = 1'b1;
          n_nxt[0] = '0;
          n_nxt[1] = '0;
          n_nxt[2] = '0;
        end
      end
      ST_POS_RD: begin
        cnt_nxt = cnt_r + 1'b1;
        case (cnt_r[1:0])
          2'd0: pos_raddr = addr_r[0];
          2'd1: pos_raddr = addr_r[1];
          default: pos_raddr = addr_r[2];
        endcase
        for (int i = 0; i < 3; i++) begin
          if (cnt_r == CNT_W'(1)) pa_nxt[i] = $signed(pos_rdata_r[CW*i +: CW]);
          if (cnt_r == CNT_W'(2)) begin
            e1_nxt[i] = EW'($signed(pos_rdata_r[CW*i +: CW])) - EW'(pa_r[i]);
          end
          if (cnt_r == CNT_W'(3)) begin
            e2_nxt[i] = EW'($signed(pos_rdata_r[CW*i +: CW])) - EW'(pa_r[i]);
          end
        end
        if (cnt_r == CNT_W'(3)) cnt_nxt = '0;
      end
      ST_CROSS: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          if (cross_j[0]) v_nxt[cross_j[2:1]] = v_r[cross_j[2:1]] - VW'(prod_r);
          else v_nxt[cross_j[2:1]] = VW'(prod_r);
        end
      end
      ST_MAG: begin
        for (int i = 0; i < 3; i++) begin
          m_nxt[i] = v_r[i][VW-1] ? (~v_r[i] + 1'b1) : v_r[i];
        end
      end
      ST_SHIFT: begin
        cnt_nxt = '0;
        s_nxt   = '0;
        if (or_m == '0) begin
          zero_nxt = 1'b1;
          n_nxt[0] = '0;
          n_nxt[1] = '0;
          n_nxt[2] = '0;
        end else if (|or_m[VW-1:30]) begin
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] >> 1;
        end else if (!(|or_m[VW-1:29])) begin
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] << 1;
        end
      end
      ST_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) s_nxt = s_r + {2'b00, prod_r};
        r_nxt   = '0;
        bit_nxt = 64'd1 << 62;
        if (cnt_r == CNT_W'(3)) cnt_nxt = '0;
      end
      ST_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (s_r >= sq_t) begin
          s_nxt = s_r - sq_t;
          r_nxt = (r_r >> 1) + bit_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        len_nxt = r_nxt[31:0];
        k_nxt   = '0;
      end
      ST_DIV_LD: begin
        cnt_nxt = '0;
        q_nxt   = '0;
        num_nxt = (DW'(m_r[k_r][29:0]) << (NORMAL_FRAC + 1)) + DW'(len_r);
        dsh_nxt = DW'({len_r, 1'b0}) << NORMAL_FRAC;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (div_ge) num_nxt = num_r - dsh_r;
        q_nxt   = {q_r[QB-2:0], div_ge};
        dsh_nxt = dsh_r >> 1;
        if (cnt_r == CNT_W'(QB - 1)) begin
          n_nxt[k_r] = v_r[k_r][VW-1] ? -$signed({1'b0, q_nxt}) : $signed({1'b0, q_nxt});
          k_nxt      = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        end
      end
      ST_ACC_RD: begin
        acc_raddr = addr_r[k_r];
      end
      ST_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = addr_r[k_r];
        acc_wdata = {sat_add(acc_rdata_r[95:64], n_r[2]),
                     sat_add(acc_rdata_r[63:32], n_r[1]),
                     sat_add(acc_rdata_r[31:0], n_r[0])};
        k_nxt     = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      ST_VLOAD: begin
        for (int i = 0; i < 3; i++) v_nxt[i] = VW'($signed(acc_rdata_r[32*i +: 32]));
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'b0, 16'(n_r[2]), 16'(n_r[1]), 16'(n_r[0]), vidx_r};
          out_tuser_nxt  = zero_r;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rdata_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rdata_r <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      cnt_r        <= '0;
      k_r          <= '0;
      is_read_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      cnt_r        <= cnt_nxt;
      k_r          <= k_nxt;
      is_read_r    <= is_read_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    zero_r      <= zero_nxt;
    addr_r      <= addr_nxt;
    vidx_r      <= vidx_nxt;
    pa_r        <= pa_nxt;
    e1_r        <= e1_nxt;
    e2_r        <= e2_nxt;
    v_r         <= v_nxt;
    m_r         <= m_nxt;
    n_r         <= n_nxt;
    prod_r      <= prod_nxt;
    s_r         <= s_nxt;
    r_r         <= r_nxt;
    bit_r       <= bit_nxt;
    len_r       <= len_nxt;
    num_r       <= num_nxt;
    dsh_r       <= dsh_nxt;
    q_r         <= q_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  `VNA_ASSERT(a_busy_after_cmd, (in_tvalid && in_tready && (in_tuser == KIND_READ || in_tuser == KIND_CLEAR)) |=> !in_tready)
  `VNA_ASSERT(a_len_range, (state_r == ST_DIV) |-> (len_r[31:29] != 3'b000))
  `VNA_ASSERT(a_out_source, $rose(out_tvalid) |-> ($past(state_r) == ST_OUT))
  `VNA_ASSERT(a_zero_normal, (out_tvalid && out_tuser[0]) |-> (out_tdata[57:10] == '0))
  `VNA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_tvalid && !in_tready))

endmodule
`default_nettype wire
